FILE: src/brace_framed_receive_fifo_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the brace framed receive FIFO
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BRACE_FRAMED_RECEIVE_FIFO_DEFINES_SVH
`define BRACE_FRAMED_RECEIVE_FIFO_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BFRF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BFRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bfrf_pkg.sv
// ----------------------------------------------------------------------------
// Brace framed receive FIFO package
// Transaction types, action and status codes and framing byte values.
// ----------------------------------------------------------------------------
package bfrf_pkg;

   localparam logic [2:0] ACT_RECEIVE = 3'd0;
   localparam logic [2:0] ACT_POP     = 3'd1;
   localparam logic [2:0] ACT_PEEK    = 3'd2;
   localparam logic [2:0] ACT_STATUS  = 3'd3;
   localparam logic [2:0] ACT_FRAME   = 3'd4;

   localparam logic [1:0] STS_OK         = 2'd0;
   localparam logic [1:0] STS_EMPTY      = 2'd1;
   localparam logic [1:0] STS_INCOMPLETE = 2'd2;
   localparam logic [1:0] STS_DROPPED    = 2'd3;

   localparam logic [7:0] OPEN_BRACE  = 8'h7B;
   localparam logic [7:0] CLOSE_BRACE = 8'h7D;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] rx_data;
      logic [6:0] max_len;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  data;
      logic        last;
      logic        frame_ready;
      logic [7:0]  fill_count;
      logic [31:0] rx_byte_count;
      logic [31:0] rx_frame_count;
      logic [31:0] overflow_count;
      logic [31:0] framing_error_count;
   } rsp_type;

endpackage

FILE: src/brace_framed_receive_fifo.sv
// ----------------------------------------------------------------------------
// Brace framed receive FIFO
// Byte ring FIFO with receive, pop, peek, status and brace-delimited frame
// reads, built around one synchronous ring memory and a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Content
//   req      in         req_valid/req_stall  bfrf_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  bfrf_pkg::rsp_type
//   csr      in         csr_valid/csr_ready  rx_enable bit
//
// Receive, status and empty pop or peek transactions run execute then emit; other pops and
// peeks add a ring read wait. A frame read alternates read and process states per scanned byte,
// then fetch and wait states per frame byte, or emits incomplete status when no frame completes.
// Reset is synchronous and clears pointers, counters and control without a clearing pass.
// A waiting result sits in the output register while the next transaction is
// accepted; output stalls hold the sequencer only when it must emit.
// ----------------------------------------------------------------------------
`include "brace_framed_receive_fifo_defines.svh"

module brace_framed_receive_fifo #(
   parameter int RING_DEPTH  = 256,
   parameter int FRAME_LIMIT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bfrf_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bfrf_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(FRAME_LIMIT);
   localparam logic [AW-1:0] DEPTH_M1 = AW'(RING_DEPTH - 1);
   localparam logic [AW-1:0] DEPTH_W  = AW'(RING_DEPTH);
   localparam logic [6:0]    LIMIT_W  = 7'(FRAME_LIMIT);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_EMIT   = 3'd3;
   localparam logic [2:0] S_FREAD  = 3'd4;
   localparam logic [2:0] S_FPROC  = 3'd5;
   localparam logic [2:0] S_FOUT   = 3'd6;
   localparam logic [2:0] S_FWAIT  = 3'd7;

   logic [7:0] ring_mem [RING_DEPTH];

   logic [2:0]        state_ff, state_in;
   logic [2:0]        op_action_ff, op_action_in;
   logic [7:0]        op_data_ff, op_data_in;
   logic [CW-1:0]     limit_ff, limit_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [AW-1:0]     rp_ff, rp_in;
   logic              inside_ff, inside_in;
   logic [31:0]       accepted_ff, accepted_in;
   logic [31:0]       frames_ff, frames_in;
   logic [31:0]       dropped_ff, dropped_in;
   logic [31:0]       discarded_ff, discarded_in;
   logic [AW-1:0]     close_cnt_ff, close_cnt_in;
   logic              rx_enable_ff, rx_enable_in;
   logic              in_fr_ff, in_fr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [AW-1:0]     start_ptr_ff, start_ptr_in;
   logic [CW-1:0]     out_idx_ff, out_idx_in;
   logic [AW-1:0]     out_ptr_ff, out_ptr_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [7:0]        res_data_ff, res_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bfrf_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic [7:0]        mem_rd_data_ff;

   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [AW-1:0]     fill;
   logic              out_free;
   logic [6:0]        sat_len;
   logic              frame_last;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      ptr_inc = (p == DEPTH_M1) ? '0 : p + 1'b1;
   endfunction

   assign fill      = (wp_ff >= rp_ff) ? wp_ff - rp_ff : wp_ff - rp_ff + DEPTH_W;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign sat_len    = (req_payload.max_len > LIMIT_W) ? LIMIT_W : req_payload.max_len;
   assign frame_last = (out_idx_ff == count_ff - 1'b1);

   always_comb begin
      state_in      = state_ff;
      op_action_in  = op_action_ff;
      op_data_in    = op_data_ff;
      limit_in      = limit_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      inside_in     = inside_ff;
      accepted_in   = accepted_ff;
      frames_in     = frames_ff;
      dropped_in    = dropped_ff;
      discarded_in  = discarded_ff;
      close_cnt_in  = close_cnt_ff;
      rx_enable_in  = (csr_valid && csr_ready) ? csr_data : rx_enable_ff;
      in_fr_in      = in_fr_ff;
      count_in      = count_ff;
      scan_ptr_in   = scan_ptr_ff;
      start_ptr_in  = start_ptr_ff;
      out_idx_in    = out_idx_ff;
      out_ptr_in    = out_ptr_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rp_ff;

      rsp_valid_in   = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_action_in = req_payload.action;
               op_data_in   = req_payload.rx_data;
               limit_in     = (sat_len == 7'd0) ? '0 : CW'(sat_len - 7'd1);
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            res_data_in   = 8'd0;
            res_status_in = bfrf_pkg::STS_OK;
            state_in      = S_EMIT;
            case (op_action_ff)
               bfrf_pkg::ACT_RECEIVE: begin
                  if (!rx_enable_ff) begin
                     res_status_in = bfrf_pkg::STS_DROPPED;
                  end else if (fill == DEPTH_M1) begin
                     dropped_in    = dropped_ff + 32'd1;
                     res_status_in = bfrf_pkg::STS_DROPPED;
                  end else begin
                     mem_wr_en   = 1'b1;
                     wp_in       = ptr_inc(wp_ff);
                     accepted_in = accepted_ff + 32'd1;
                     if (op_data_ff == bfrf_pkg::OPEN_BRACE) begin
                        inside_in = 1'b1;
                     end else if (op_data_ff == bfrf_pkg::CLOSE_BRACE && inside_ff) begin
                        frames_in = frames_ff + 32'd1;
                        inside_in = 1'b0;
                     end
                     if (op_data_ff == bfrf_pkg::CLOSE_BRACE) begin
                        close_cnt_in = close_cnt_ff + 1'b1;
                     end
                  end
               end
               bfrf_pkg::ACT_POP, bfrf_pkg::ACT_PEEK: begin
                  if (fill == '0) begin
                     res_status_in = bfrf_pkg::STS_EMPTY;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = S_RDWAIT;
                  end
               end
               bfrf_pkg::ACT_FRAME: begin
                  in_fr_in = 1'b0;
                  count_in = '0;
                  state_in = S_FREAD;
               end
               default: begin
                  res_status_in = bfrf_pkg::STS_OK;
               end
            endcase
         end
         S_RDWAIT: begin
            res_data_in = mem_rd_data_ff;
            if (op_action_ff == bfrf_pkg::ACT_POP) begin
               rp_in = ptr_inc(rp_ff);
               if (mem_rd_data_ff == bfrf_pkg::CLOSE_BRACE) begin
                  close_cnt_in = close_cnt_ff - 1'b1;
               end
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.status     = res_status_ff;
               rsp_payload_in.data       = res_data_ff;
               rsp_payload_in.last       = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         S_FREAD: begin
            if (count_ff < limit_ff && fill != '0) begin
               mem_rd_en   = 1'b1;
               scan_ptr_in = rp_ff;
               rp_in       = ptr_inc(rp_ff);
               state_in    = S_FPROC;
            end else begin
               res_status_in = bfrf_pkg::STS_INCOMPLETE;
               res_data_in   = 8'd0;
               state_in      = S_EMIT;
            end
         end
         S_FPROC: begin
            state_in = S_FREAD;
            if (mem_rd_data_ff == bfrf_pkg::CLOSE_BRACE) begin
               close_cnt_in = close_cnt_ff - 1'b1;
            end
            if (mem_rd_data_ff == bfrf_pkg::OPEN_BRACE) begin
               in_fr_in     = 1'b1;
               count_in     = CW'(1);
               start_ptr_in = scan_ptr_ff;
            end else if (in_fr_ff) begin
               count_in = count_ff + 1'b1;
               if (mem_rd_data_ff == bfrf_pkg::CLOSE_BRACE) begin
                  out_idx_in = '0;
                  out_ptr_in = start_ptr_ff;
                  state_in   = S_FOUT;
               end
            end else begin
               discarded_in = discarded_ff + 32'd1;
            end
         end
         S_FOUT: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = out_ptr_ff;
            state_in    = S_FWAIT;
         end
         S_FWAIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_payload_in.status = bfrf_pkg::STS_OK;
               rsp_payload_in.data   = mem_rd_data_ff;
               rsp_payload_in.last   = frame_last;
               if (frame_last) begin
                  state_in = S_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 1'b1;
                  out_ptr_in = ptr_inc(out_ptr_ff);
                  state_in   = S_FOUT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if ((state_ff == S_EMIT || state_ff == S_FWAIT) && out_free) begin
         rsp_payload_in.frame_ready         = (close_cnt_ff != '0);
         rsp_payload_in.fill_count          = 8'(fill);
         rsp_payload_in.rx_byte_count       = accepted_ff;
         rsp_payload_in.rx_frame_count      = frames_ff;
         rsp_payload_in.overflow_count      = dropped_ff;
         rsp_payload_in.framing_error_count = discarded_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         ring_mem[wp_ff] <= op_data_ff;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= ring_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         inside_ff    <= 1'b0;
         accepted_ff  <= '0;
         frames_ff    <= '0;
         dropped_ff   <= '0;
         discarded_ff <= '0;
         close_cnt_ff <= '0;
         rx_enable_ff <= 1'b0;
         in_fr_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         inside_ff    <= inside_in;
         accepted_ff  <= accepted_in;
         frames_ff    <= frames_in;
         dropped_ff   <= dropped_in;
         discarded_ff <= discarded_in;
         close_cnt_ff <= close_cnt_in;
         rx_enable_ff <= rx_enable_in;
         in_fr_ff     <= in_fr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_action_ff   <= op_action_in;
      op_data_ff     <= op_data_in;
      limit_ff       <= limit_in;
      scan_ptr_ff    <= scan_ptr_in;
      start_ptr_ff   <= start_ptr_in;
      out_idx_ff     <= out_idx_in;
      out_ptr_ff     <= out_ptr_in;
      res_status_ff  <= res_status_in;
      res_data_ff    <= res_data_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   `BFRF_ASSERT_IMPL(a_close_within_fill, clock, reset, state_ff != S_FPROC,
      close_cnt_ff <= fill, "more closing braces than bytes held")
   `BFRF_ASSERT_IMPL(a_no_write_when_full, clock, reset, mem_wr_en,
      fill != DEPTH_M1, "ring write while full")
   `BFRF_ASSERT_IMPL(a_frame_not_empty, clock, reset, state_ff == S_FOUT || state_ff == S_FWAIT,
      count_ff != '0, "frame emit with zero length")
   `BFRF_ASSERT_NEXT(a_last_returns_idle, clock, reset, state_ff == S_FWAIT && out_free && frame_last,
      state_ff == S_IDLE, "frame end did not return to idle")

endmodule
